### rtl/core/ascm_pkg.sv
// ----------------------------------------------------------------------------
// ascm_pkg
// Shared types, register indexes, command codes and neighbour offsets.
// ----------------------------------------------------------------------------
package ascm_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	typedef struct packed {
		logic        action;
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} in_item_t;

	typedef struct packed {
		logic       refine;
		logic       edge_res;
		logic [9:0] pixel_column;
		logic [9:0] pixel_row;
		logic       frame_last;
	} out_item_t;

	localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_LUMA_FLOOR     = 3'd2;
	localparam logic [2:0] REG_CONTRAST_RATIO = 3'd3;
	localparam logic [2:0] REG_WEIGHT_RED     = 3'd4;
	localparam logic [2:0] REG_WEIGHT_GREEN   = 3'd5;
	localparam logic [2:0] REG_WEIGHT_BLUE    = 3'd6;

	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_ACCEPT = 3'd1;
	localparam logic [2:0] OP_MUL    = 3'd2;
	localparam logic [2:0] OP_LWRITE = 3'd3;
	localparam logic [2:0] OP_ESCAN  = 3'd4;
	localparam logic [2:0] OP_EWRITE = 3'd5;
	localparam logic [2:0] OP_GSCAN  = 3'd6;
	localparam logic [2:0] OP_EMIT   = 3'd7;

	localparam logic [3:0] MUL_LAST   = 4'd3;
	localparam logic [3:0] NB_LAST    = 4'd8;
	localparam logic [3:0] ESCAN_LAST = 4'd10;
	localparam logic [3:0] GSCAN_LAST = 4'd9;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] step;
	} cmd_t;

	typedef struct packed {
		logic pix_take;
		logic edge_ready;
		logic out_ready;
		logic out_free;
	} status_t;

	// step 0 is the centre, 1..8 the neighbours in raster order
	function automatic logic [1:0] nb_dy(input logic [3:0] k);
		logic [1:0] d;
		case (k)
			4'd1, 4'd2, 4'd3: d = 2'b11;
			4'd6, 4'd7, 4'd8: d = 2'b01;
			default:          d = 2'b00;
		endcase
		return d;
	endfunction

	function automatic logic [1:0] nb_dx(input logic [3:0] k);
		logic [1:0] d;
		case (k)
			4'd1, 4'd4, 4'd6: d = 2'b11;
			4'd3, 4'd5, 4'd8: d = 2'b01;
			default:          d = 2'b00;
		endcase
		return d;
	endfunction

endpackage

### rtl/core/ascm_ctrl.sv
// ----------------------------------------------------------------------------
// ascm_ctrl
// Sequencer: one transaction at a time through luma, edge and dilation steps.
// ----------------------------------------------------------------------------
module ascm_ctrl import ascm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_LWR   = 4'd2;
	localparam logic [3:0] S_ECHK  = 4'd3;
	localparam logic [3:0] S_ESCAN = 4'd4;
	localparam logic [3:0] S_EWR   = 4'd5;
	localparam logic [3:0] S_GSCAN = 4'd6;
	localparam logic [3:0] S_EMIT  = 4'd7;

	logic [3:0] state_q, state_n;
	logic [3:0] step_q, step_n;

	always_comb begin
		state_n  = state_q;
		step_n   = step_q;
		cmd.op   = OP_NONE;
		cmd.step = step_q;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_ACCEPT;
					step_n  = 4'd0;
					state_n = status.pix_take ? S_MUL : S_ECHK;
				end
			end
			S_MUL: begin
				cmd.op = OP_MUL;
				if (step_q == MUL_LAST) begin
					state_n = S_LWR;
				end else begin
					step_n = step_q + 4'd1;
				end
			end
			S_LWR: begin
				cmd.op  = OP_LWRITE;
				state_n = S_ECHK;
			end
			S_ECHK: begin
				step_n = 4'd0;
				if (status.edge_ready) begin
					state_n = S_ESCAN;
				end else if (status.out_ready) begin
					state_n = S_GSCAN;
				end else begin
					state_n = S_IDLE;
				end
			end
			S_ESCAN: begin
				cmd.op = OP_ESCAN;
				if (step_q == ESCAN_LAST) begin
					state_n = S_EWR;
				end else begin
					step_n = step_q + 4'd1;
				end
			end
			S_EWR: begin
				cmd.op  = OP_EWRITE;
				state_n = S_ECHK;
			end
			S_GSCAN: begin
				cmd.op = OP_GSCAN;
				if (step_q == GSCAN_LAST) begin
					state_n = S_EMIT;
				end else begin
					step_n = step_q + 4'd1;
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.op  = OP_EMIT;
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= 4'd0;
		end else begin
			state_q <= state_n;
			step_q  <= step_n;
		end
	end

endmodule

### rtl/core/ascm_datapath.sv
// ----------------------------------------------------------------------------
// ascm_datapath
// Registers, positions, line stores, luma multiplier and ratio comparator.
// ----------------------------------------------------------------------------
module ascm_datapath import ascm_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  in_item_t  in_data,
	input  cmd_t      cmd,
	output status_t   status,
	input  logic      out_stall,
	output logic      out_valid,
	output out_item_t out_data
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int AW    = CW + 2;
	localparam int DEPTH = 4 * (2 ** CW);

	typedef struct packed {
		logic          full;
		logic [RW-1:0] row;
		logic [CW-1:0] col;
	} pos_t;

	logic [10:0] frame_width_q, frame_height_q;
	logic [15:0] luma_floor_q, contrast_ratio_q;
	logic [15:0] weight_red_q, weight_green_q, weight_blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q    <= 11'd1024;
			frame_height_q   <= 11'd1024;
			luma_floor_q     <= 16'd20;
			contrast_ratio_q <= 16'd36214;
			weight_red_q     <= 16'd13933;
			weight_green_q   <= 16'd46871;
			weight_blue_q    <= 16'd4732;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:    frame_width_q    <= cfg_data[10:0];
				REG_FRAME_HEIGHT:   frame_height_q   <= cfg_data[10:0];
				REG_LUMA_FLOOR:     luma_floor_q     <= cfg_data;
				REG_CONTRAST_RATIO: contrast_ratio_q <= cfg_data;
				REG_WEIGHT_RED:     weight_red_q     <= cfg_data;
				REG_WEIGHT_GREEN:   weight_green_q   <= cfg_data;
				REG_WEIGHT_BLUE:    weight_blue_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamped geometry as last index
	logic [31:0] wlim, hlim, wm1_full, hm1_full;
	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;

	always_comb begin
		wlim = 32'(frame_width_q);
		if (wlim == 32'd0) wlim = 32'd1;
		else if (wlim > 32'(MAX_WIDTH)) wlim = 32'(MAX_WIDTH);
		hlim = 32'(frame_height_q);
		if (hlim == 32'd0) hlim = 32'd1;
		else if (hlim > 32'(MAX_HEIGHT)) hlim = 32'(MAX_HEIGHT);
		wm1_full = wlim - 32'd1;
		hm1_full = hlim - 32'd1;
		wm1 = wm1_full[CW-1:0];
		hm1 = hm1_full[RW-1:0];
	end

	function automatic pos_t step_pos(input pos_t p, input logic [CW-1:0] lc,
			input logic [RW-1:0] lr);
		pos_t n;
		n = p;
		if (p.col < lc) begin
			n.col = p.col + 1'b1;
		end else begin
			n.col = '0;
			if (p.row < lr) begin
				n.row = p.row + 1'b1;
			end else begin
				n.row  = '0;
				n.full = 1'b1;
			end
		end
		return n;
	endfunction

	pos_t in_pos_q, ed_pos_q, op_pos_q, op_next;
	logic frame_end;

	assign op_next   = step_pos(op_pos_q, wm1, hm1);
	assign frame_end = (op_pos_q.row == hm1) && (op_pos_q.col == wm1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pos_q <= '0;
			ed_pos_q <= '0;
			op_pos_q <= '0;
		end else if (cfg_write && (cfg_index == REG_FRAME_WIDTH ||
				cfg_index == REG_FRAME_HEIGHT)) begin
			in_pos_q <= '0;
			ed_pos_q <= '0;
			op_pos_q <= '0;
		end else begin
			case (cmd.op)
				OP_LWRITE: in_pos_q <= step_pos(in_pos_q, wm1, hm1);
				OP_EWRITE: ed_pos_q <= step_pos(ed_pos_q, wm1, hm1);
				OP_EMIT: begin
					if (frame_end) begin
						in_pos_q <= '0;
						ed_pos_q <= '0;
						op_pos_q <= '0;
					end else begin
						op_pos_q <= op_next;
					end
				end
				default: ;
			endcase
		end
	end

	// readiness: clipped lower-right neighbour already past
	logic [RW:0] er1, or1;
	logic [CW:0] ec1, oc1;
	logic [RW-1:0] er_t, or_t;
	logic [CW-1:0] ec_t, oc_t;

	always_comb begin
		er1  = {1'b0, ed_pos_q.row} + 1'b1;
		ec1  = {1'b0, ed_pos_q.col} + 1'b1;
		or1  = {1'b0, op_pos_q.row} + 1'b1;
		oc1  = {1'b0, op_pos_q.col} + 1'b1;
		er_t = (er1 > {1'b0, hm1}) ? hm1 : er1[RW-1:0];
		ec_t = (ec1 > {1'b0, wm1}) ? wm1 : ec1[CW-1:0];
		or_t = (or1 > {1'b0, hm1}) ? hm1 : or1[RW-1:0];
		oc_t = (oc1 > {1'b0, wm1}) ? wm1 : oc1[CW-1:0];
	end

	assign status.pix_take   = !in_data.action && !in_pos_q.full;
	assign status.edge_ready = !ed_pos_q.full && (in_pos_q.full ||
		(er_t < in_pos_q.row) || ((er_t == in_pos_q.row) && (ec_t < in_pos_q.col)));
	assign status.out_ready  = ed_pos_q.full ||
		(or_t < ed_pos_q.row) || ((or_t == ed_pos_q.row) && (oc_t < ed_pos_q.col));
	assign status.out_free   = !out_valid || !out_stall;

	// luma: one shared multiplier, three products
	in_item_t    item_q;
	logic [15:0] mul_w, mul_c, luma;
	logic [31:0] prod_q;
	logic [33:0] acc_q;
	logic [34:0] rnd;
	logic [18:0] lsh;

	always_comb begin
		case (cmd.step)
			4'd0:    begin mul_w = weight_red_q;   mul_c = item_q.red;   end
			4'd1:    begin mul_w = weight_green_q; mul_c = item_q.green; end
			default: begin mul_w = weight_blue_q;  mul_c = item_q.blue;  end
		endcase
		rnd  = {1'b0, acc_q} + 35'd32768;
		lsh  = rnd[34:16];
		luma = (lsh > 19'd65535) ? 16'hFFFF : lsh[15:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ACCEPT) begin
			item_q <= in_data;
			acc_q  <= '0;
		end
		if (cmd.op == OP_MUL) begin
			if (cmd.step <= 4'd2) prod_q <= mul_w * mul_c;
			if (cmd.step >= 4'd1) acc_q <= acc_q + 34'(prod_q);
		end
	end

	// neighbour address
	logic [RW-1:0] base_row;
	logic [CW-1:0] base_col;
	logic [1:0]    dy, dx;
	logic [RW+1:0] yy;
	logic [CW+1:0] xx;
	logic          issue, inframe;
	logic [AW-1:0] raddr;

	always_comb begin
		base_row = (cmd.op == OP_GSCAN) ? op_pos_q.row : ed_pos_q.row;
		base_col = (cmd.op == OP_GSCAN) ? op_pos_q.col : ed_pos_q.col;
		dy       = nb_dy(cmd.step);
		dx       = nb_dx(cmd.step);
		yy       = {2'b00, base_row} + {{RW{dy[1]}}, dy};
		xx       = {2'b00, base_col} + {{CW{dx[1]}}, dx};
		issue    = (cmd.op == OP_ESCAN || cmd.op == OP_GSCAN) && (cmd.step <= NB_LAST);
		inframe  = issue && !yy[RW+1] && (yy[RW:0] <= {1'b0, hm1}) &&
			!xx[CW+1] && (xx[CW:0] <= {1'b0, wm1});
		raddr    = {yy[1:0], xx[CW-1:0]};
	end

	// line stores
	logic [15:0] luma_mem [DEPTH];
	logic        edge_mem [DEPTH];
	logic [15:0] lrd_q;
	logic        erd_q;
	logic        eflag_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LWRITE) luma_mem[{in_pos_q.row[1:0], in_pos_q.col}] <= luma;
		lrd_q <= luma_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EWRITE) edge_mem[{ed_pos_q.row[1:0], ed_pos_q.col}] <= eflag_q;
		erd_q <= edge_mem[raddr];
	end

	// contrast test: hi * 32768 > lo * ratio
	logic        ev_s1, ec_s1, ev_s2;
	logic        gv_s1, gc_s1;
	logic [15:0] centre_q;
	logic [16:0] fa, fb, hi, lo;
	logic [16:0] hi_s2;
	logic [32:0] prod_s2;
	logic        gflag_q, eres_q;

	always_comb begin
		fa = {1'b0, centre_q} + {1'b0, luma_floor_q};
		fb = {1'b0, lrd_q} + {1'b0, luma_floor_q};
		hi = (fa > fb) ? fa : fb;
		lo = (fa > fb) ? fb : fa;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s1   <= 1'b0;
			ec_s1   <= 1'b0;
			ev_s2   <= 1'b0;
			gv_s1   <= 1'b0;
			gc_s1   <= 1'b0;
			eflag_q <= 1'b0;
			gflag_q <= 1'b0;
		end else begin
			ev_s1 <= (cmd.op == OP_ESCAN) && inframe;
			ec_s1 <= (cmd.step == 4'd0);
			ev_s2 <= ev_s1 && !ec_s1;
			gv_s1 <= (cmd.op == OP_GSCAN) && inframe;
			gc_s1 <= (cmd.step == 4'd0);
			if (cmd.op == OP_ESCAN && cmd.step == 4'd0) begin
				eflag_q <= 1'b0;
			end else if (ev_s2 && ({1'b0, hi_s2, 15'd0} > prod_s2)) begin
				eflag_q <= 1'b1;
			end
			if (cmd.op == OP_GSCAN && cmd.step == 4'd0) begin
				gflag_q <= 1'b0;
			end else if (gv_s1 && erd_q) begin
				gflag_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_s1 && ec_s1) centre_q <= lrd_q;
		hi_s2   <= hi;
		prod_s2 <= lo * contrast_ratio_q;
		if (gv_s1 && gc_s1) eres_q <= erd_q;
	end

	// output register
	logic [31:0] oc32, or32;
	out_item_t   out_q;
	logic        out_valid_q;

	assign oc32 = 32'(op_pos_q.col);
	assign or32 = 32'(op_pos_q.row);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT) begin
			out_q.refine       <= gflag_q;
			out_q.edge_res     <= eres_q;
			out_q.pixel_column <= oc32[9:0];
			out_q.pixel_row    <= or32[9:0];
			out_q.frame_last   <= frame_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### rtl/core/adaptive_sample_contrast_mask.sv
// ----------------------------------------------------------------------------
// adaptive_sample_contrast_mask
// Luma contrast edge mask with 3x3 dilation for adaptive sampling.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A pixel goes through luma
// (one shared 16x16 multiplier over three products, then the line store
// write), each edge flag it releases takes nine reads of the luma line
// store through a two-stage ratio comparator and a result takes nine
// reads of the edge line store; a drain does only the edge and result
// work it releases. The next transaction is not taken until all of that
// is done. Results trail the input by about two rows; drain transactions
// flush the tail of a frame. No clearing pass is needed after reset.
module adaptive_sample_contrast_mask import ascm_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data
);

	cmd_t    cmd;
	status_t status;

	ascm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	ascm_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT |-> status.out_free)
		else $error("result loaded over an untaken one");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second transaction taken while busy");

	a_write_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_LWRITE |-> $past(cmd.op) == OP_MUL)
		else $error("luma written without products");
`endif

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Contrast mask testbench
// Drives raster frames and drain transactions into the edge mask block,
// predicts every result from a local model of the luma contrast test and its
// 3x3 dilation, and checks each whole result against it in arrival order.
// ----------------------------------------------------------------------------
module testbench;
	import ascm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAXW = MAX_WIDTH_DEF;
	localparam int MAXH = MAX_HEIGHT_DEF;

	logic       clk;
	logic       arst_n;
	logic       cfg_write;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;

	adaptive_sample_contrast_mask i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// mask model state
	logic [15:0] luma_mem [4][MAXW];
	bit          flag_mem [4][MAXW];
	int unsigned in_r, in_c, ed_r, ed_c, op_r, op_c;
	bit          in_full, ed_full, op_full;
	logic [10:0] geo_width, geo_height;
	logic [15:0] floor_q, ratio_q, w_red, w_green, w_blue;
	bit          frame_closed;

	out_item_t   expected_results[$];
	int          mismatches;
	int          items_sent;
	int          burst_left;
	int          stall_pct;
	int          stall_age;

	function automatic int unsigned cur_w();
		if (geo_width < 1) return 1;
		if (geo_width > MAXW) return MAXW;
		return 32'(geo_width);
	endfunction

	function automatic int unsigned cur_h();
		if (geo_height < 1) return 1;
		if (geo_height > MAXH) return MAXH;
		return 32'(geo_height);
	endfunction

	function automatic void frame_restart();
		in_r = 0; in_c = 0; ed_r = 0; ed_c = 0; op_r = 0; op_c = 0;
		in_full = 0; ed_full = 0; op_full = 0;
	endfunction

	function automatic void raster_next(ref int unsigned r, ref int unsigned c, ref bit full);
		if (c + 1 < cur_w()) begin
			c++;
		end else begin
			c = 0;
			if (r + 1 < cur_h()) r++;
			else begin
				r = 0;
				full = 1;
			end
		end
	endfunction

	function automatic int unsigned arrived(int unsigned r, int unsigned c, bit full);
		return full ? cur_w() * cur_h() : r * cur_w() + c;
	endfunction

	function automatic int unsigned lag_index(int unsigned r, int unsigned c);
		int unsigned rr, cc;
		rr = (r + 1 > cur_h() - 1) ? cur_h() - 1 : r + 1;
		cc = (c + 1 > cur_w() - 1) ? cur_w() - 1 : c + 1;
		return rr * cur_w() + cc;
	endfunction

	function automatic bit contrast_hit(logic [15:0] p, logic [15:0] q);
		longint unsigned a, b, hi, lo;
		a = p + floor_q;
		b = q + floor_q;
		hi = (a > b) ? a : b;
		lo = (a > b) ? b : a;
		return hi * 32768 > lo * ratio_q;
	endfunction

	function automatic bit edge_of(int unsigned r, int unsigned c);
		logic [15:0] centre;
		int yy, xx;
		centre = luma_mem[r % 4][c];
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				yy = int'(r) + dy;
				xx = int'(c) + dx;
				if ((dx != 0 || dy != 0) && yy >= 0 && yy < int'(cur_h())
						&& xx >= 0 && xx < int'(cur_w()))
					if (contrast_hit(centre, luma_mem[yy % 4][xx])) return 1;
			end
		end
		return 0;
	endfunction

	function automatic bit dilated_of(int unsigned r, int unsigned c);
		int yy, xx;
		for (int dy = -1; dy <= 1; dy++) begin
			for (int dx = -1; dx <= 1; dx++) begin
				yy = int'(r) + dy;
				xx = int'(c) + dx;
				if (yy >= 0 && yy < int'(cur_h()) && xx >= 0 && xx < int'(cur_w()))
					if (flag_mem[yy % 4][xx]) return 1;
			end
		end
		return 0;
	endfunction

	function automatic bit mask_predict(in_item_t it, output out_item_t res);
		longint unsigned sum;
		res = '0;
		if (it.action == 1'b0 && !in_full) begin
			sum = longint'(w_red) * it.red + longint'(w_green) * it.green
				+ longint'(w_blue) * it.blue;
			sum = (sum + 32768) >> 16;
			if (sum > 65535) sum = 65535;
			luma_mem[in_r % 4][in_c] = sum[15:0];
			raster_next(in_r, in_c, in_full);
		end
		while (!ed_full && lag_index(ed_r, ed_c) < arrived(in_r, in_c, in_full)) begin
			flag_mem[ed_r % 4][ed_c] = edge_of(ed_r, ed_c);
			raster_next(ed_r, ed_c, ed_full);
		end
		if (op_full || lag_index(op_r, op_c) >= arrived(ed_r, ed_c, ed_full)) return 0;
		res.refine       = dilated_of(op_r, op_c);
		res.edge_res     = flag_mem[op_r % 4][op_c];
		res.pixel_column = op_c[9:0];
		res.pixel_row    = op_r[9:0];
		res.frame_last   = (op_r == cur_h() - 1 && op_c == cur_w() - 1);
		raster_next(op_r, op_c, op_full);
		if (op_full) begin
			frame_restart();
			frame_closed = 1;
		end
		return 1;
	endfunction

	// receiver stall pattern; the stall percentage is redrawn whenever a random countdown expires
	always @(posedge clk) begin
		if (stall_age == 0) begin
			stall_age <= $urandom_range(50, 400);
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 20;
				2: stall_pct <= 50;
				default: stall_pct <= 85;
			endcase
		end else begin
			stall_age <= stall_age - 1;
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				if (out_data !== expected_results[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p actual %p",
							expected_results[0], out_data);
				end
				void'(expected_results.pop_front());
			end
		end
	end

	task automatic send_item(in_item_t it);
		out_item_t res;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		burst_left--;
		items_sent++;
		if (mask_predict(it, res)) expected_results.push_back(res);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic wait_idle();
		wait_results();
		repeat (40 * cur_w() + 200) @(posedge clk);
	endtask

	task automatic cfg_set(logic [2:0] idx, logic [15:0] val);
		wait_idle();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH: begin
				geo_width = val[10:0];
				frame_restart();
			end
			REG_FRAME_HEIGHT: begin
				geo_height = val[10:0];
				frame_restart();
			end
			REG_LUMA_FLOOR:     floor_q = val;
			REG_CONTRAST_RATIO: ratio_q = val;
			REG_WEIGHT_RED:     w_red = val;
			REG_WEIGHT_GREEN:   w_green = val;
			default:            w_blue = val;
		endcase
	endtask

	function automatic in_item_t pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
		in_item_t it;
		it.action = 1'b0;
		it.red = r;
		it.green = g;
		it.blue = b;
		return it;
	endfunction

	function automatic in_item_t drain_item();
		in_item_t it;
		it.action = 1'b1;
		it.red = 16'($urandom());
		it.green = 16'($urandom());
		it.blue = 16'($urandom());
		return it;
	endfunction

	// mostly flat areas with occasional steps, so edges stay sparse
	function automatic in_item_t scene_pixel(logic [15:0] base);
		case ($urandom_range(0, 9))
			0, 1: return pixel(16'($urandom()), 16'($urandom()), 16'($urandom()));
			2:    return pixel(base ^ 16'h0f00, base, base ^ 16'h00f0);
			default: return pixel(16'(base + $urandom_range(0, 3)),
				16'(base + $urandom_range(0, 3)), 16'(base + $urandom_range(0, 3)));
		endcase
	endfunction

	// drains until the open frame has delivered its last result
	task automatic flush_frame();
		frame_closed = !(in_full || in_r != 0 || in_c != 0);
		while (!frame_closed) send_item(drain_item());
	endtask

	task automatic run_frame(int unsigned count, bit noisy);
		logic [15:0] base;
		base = 16'($urandom());
		for (int unsigned k = 0; k < count; k++) begin
			if (noisy && $urandom_range(0, 9) == 0) send_item(drain_item());
			if ($urandom_range(0, 19) == 0) base = 16'($urandom());
			send_item(scene_pixel(base));
		end
	endtask

	task automatic test_directed();
		cfg_set(REG_FRAME_WIDTH, 16'd4);
		cfg_set(REG_FRAME_HEIGHT, 16'd3);
		send_item(drain_item());
		send_item(pixel(16'h0000, 16'h0000, 16'h0000));
		send_item(pixel(16'hffff, 16'hffff, 16'hffff));
		send_item(pixel(16'hffff, 16'h0000, 16'h0000));
		send_item(pixel(16'h0000, 16'hffff, 16'h0000));
		send_item(pixel(16'h0000, 16'h0000, 16'hffff));
		send_item(pixel(16'h1000, 16'h1000, 16'h1000));
		send_item(pixel(16'h1001, 16'h1000, 16'h1000));
		send_item(drain_item());
		send_item(pixel(16'h1000, 16'h1000, 16'h1000));
		send_item(pixel(16'h8000, 16'h4000, 16'h2000));
		send_item(pixel(16'h5555, 16'haaaa, 16'h5555));
		send_item(pixel(16'haaaa, 16'h5555, 16'haaaa));
		send_item(pixel(16'h0001, 16'h0001, 16'h0001));
		// pixel after the last one of the frame acts as a drain
		send_item(pixel(16'h1234, 16'h5678, 16'h9abc));
		flush_frame();
		send_item(drain_item());
	endtask

	task automatic test_arithmetic();
		cfg_set(REG_FRAME_WIDTH, 16'd3);
		cfg_set(REG_FRAME_HEIGHT, 16'd3);
		cfg_set(REG_WEIGHT_RED, 16'hffff);
		cfg_set(REG_WEIGHT_GREEN, 16'hffff);
		cfg_set(REG_WEIGHT_BLUE, 16'hffff);
		run_frame(9, 0);
		flush_frame();
		cfg_set(REG_CONTRAST_RATIO, 16'd0);
		cfg_set(REG_LUMA_FLOOR, 16'd0);
		cfg_set(REG_WEIGHT_RED, 16'd0);
		cfg_set(REG_WEIGHT_GREEN, 16'd0);
		cfg_set(REG_WEIGHT_BLUE, 16'd0);
		run_frame(9, 0);
		flush_frame();
		cfg_set(REG_WEIGHT_GREEN, 16'd46871);
		for (int k = 0; k < 9; k++)
			send_item(pixel(16'h0000, (k % 2 == 1) ? 16'h4000 : 16'h0000, 16'h0000));
		flush_frame();
		cfg_set(REG_CONTRAST_RATIO, 16'hffff);
		cfg_set(REG_LUMA_FLOOR, 16'hffff);
		run_frame(9, 1);
		flush_frame();
		cfg_set(REG_CONTRAST_RATIO, 16'd32768);
		cfg_set(REG_LUMA_FLOOR, 16'd1);
		run_frame(9, 1);
		flush_frame();
	endtask

	task automatic test_geometry();
		cfg_set(REG_FRAME_WIDTH, 16'd2047);
		cfg_set(REG_FRAME_HEIGHT, 16'd2047);
		run_frame(6, 0);
		cfg_set(REG_FRAME_WIDTH, 16'd1024);
		cfg_set(REG_FRAME_HEIGHT, 16'd1);
		run_frame(5, 0);
		cfg_set(REG_FRAME_WIDTH, 16'd0);
		cfg_set(REG_FRAME_HEIGHT, 16'd0);
		run_frame(1, 0);
		flush_frame();
		cfg_set(REG_FRAME_HEIGHT, 16'd6);
		run_frame(6, 1);
		flush_frame();
		cfg_set(REG_FRAME_WIDTH, 16'd7);
		cfg_set(REG_FRAME_HEIGHT, 16'd1);
		run_frame(7, 1);
		flush_frame();
	endtask

	task automatic test_random();
		int unsigned n;
		while (items_sent < 650) begin
			cfg_set(REG_FRAME_WIDTH, 16'($urandom_range(1, 9)));
			cfg_set(REG_FRAME_HEIGHT, 16'($urandom_range(1, 7)));
			if ($urandom_range(0, 1))
				cfg_set(REG_LUMA_FLOOR, 16'($urandom_range(1, 4000)));
			if ($urandom_range(0, 1))
				cfg_set(REG_CONTRAST_RATIO, 16'($urandom_range(32768, 65535)));
			if ($urandom_range(0, 3) == 0) cfg_set(REG_WEIGHT_RED, 16'($urandom()));
			for (int f = 0; f < 3; f++) begin
				n = cur_w() * cur_h();
				if ($urandom_range(0, 7) == 0) begin
					run_frame($urandom_range(0, n), 1);
					break;
				end
				run_frame(n / 2, 1);
				if (f == 1) wait_results();
				run_frame(n - n / 2, 1);
				flush_frame();
			end
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		cfg_write <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		in_data   <= '0;
		out_stall <= 1'b0;
		stall_pct  = 0;
		stall_age  = 0;
		mismatches = 0;
		items_sent = 0;
		burst_left = 0;
		geo_width  = 11'd1024;
		geo_height = 11'd1024;
		floor_q = 16'd20;
		ratio_q = 16'd36214;
		w_red   = 16'd13933;
		w_green = 16'd46871;
		w_blue  = 16'd4732;
		frame_restart();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_arithmetic();
		test_geometry();
		test_random();
		wait_idle();
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
